// ===== sv/tta_pkg.sv =====
// Shared types, constants and command/status structs of the tangent accumulator.
package tta_pkg;

  localparam int MAX_VERTICES = 4096;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int Q_W          = 32;

  // Last step of the edge/determinant product sequence and of the projection sums.
  localparam int MUL_LAST  = 14;
  localparam int PMUL_LAST = 6;

  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_TRI  = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DEGEN = 2'd1;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLR,
    OP_LOAD,
    OP_RDS,
    OP_RDSC,
    OP_RDV,
    OP_DELTA,
    OP_MUL,
    OP_DEGEN,
    OP_DIVGO,
    OP_DIVW,
    OP_NSET,
    OP_NSHIFT,
    OP_PMUL,
    OP_PNUM,
    OP_PDGO,
    OP_PDW,
    OP_ACR,
    OP_ACW,
    OP_RESULT
  } dp_op_t;

  typedef struct packed {
    logic             idle;
    dp_op_t           op;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic [1:0] act;
    logic       d_zero;
    logic       m_zero;
    logic       m_big;
    logic       div_done;
    logic       out_full;
  } stat_t;

endpackage

// ===== sv/tta_div.sv =====
// Radix-2 restoring divider: 32-bit quotient of an 80-bit by a 64-bit magnitude.
module tta_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [79:0] num,
  input  logic [63:0] den,
  output logic        done,
  output logic [31:0] quo,
  output logic        ovf
);
  import tta_pkg::*;

  logic [63:0] rem;
  logic [31:0] nlo;
  logic [63:0] dreg;
  logic [5:0]  cnt;
  logic        busy;
  logic [64:0] r2;
  logic        ge;

  assign r2 = {rem, nlo[31]};
  assign ge = r2 >= {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ovf  <= num[79:32] >= den[47:0] && den[63:48] == 16'd0;
      rem  <= {16'd0, num[79:32]};
      nlo  <= num[31:0];
      dreg <= den;
      quo  <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= 64'(r2 - {1'b0, dreg});
      end else begin
        rem <= r2[63:0];
      end
      nlo <= {nlo[30:0], 1'b0};
      quo <= {quo[30:0], ge};
    end
  end

endmodule

// ===== sv/tta_datapath.sv =====
// Datapath: vertex and sum memories, shared multiplier, divider and result register.
module tta_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  tta_pkg::cmd_t                     cmd,
  output tta_pkg::stat_t                    stat,
  input  logic                              in_valid,
  input  logic [1:0]                        action,
  input  logic [tta_pkg::IDX_W-1:0]         vertex_slot,
  input  logic signed [tta_pkg::Q_W-1:0]    pos_x,
  input  logic signed [tta_pkg::Q_W-1:0]    pos_y,
  input  logic signed [tta_pkg::Q_W-1:0]    pos_z,
  input  logic signed [tta_pkg::Q_W-1:0]    tex_u,
  input  logic signed [tta_pkg::Q_W-1:0]    tex_v,
  input  logic [tta_pkg::IDX_W-1:0]         corner_a,
  input  logic [tta_pkg::IDX_W-1:0]         corner_b,
  input  logic [tta_pkg::IDX_W-1:0]         corner_c,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [1:0]                        status,
  output logic signed [tta_pkg::Q_W-1:0]    tangent_x,
  output logic signed [tta_pkg::Q_W-1:0]    tangent_y,
  output logic signed [tta_pkg::Q_W-1:0]    tangent_z,
  output logic                              saturated
);
  import tta_pkg::*;

  localparam logic signed [31:0] QMAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] QMIN = 32'sh80000000;

  function automatic logic [32:0] sub_sat(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [32:0] d;
    d = {a[31], a} - {b[31], b};
    if (d > 33'sh07FFFFFFF) return {1'b1, QMAX};
    if (d < -33'sh07FFFFFFF) return {1'b1, 32'sh80000001};
    return {1'b0, d[31:0]};
  endfunction

  function automatic logic [32:0] clip34(logic signed [33:0] v);
    if (v > 34'sh07FFFFFFF) return {1'b1, QMAX};
    if (v < -34'sh080000000) return {1'b1, QMIN};
    return {1'b0, v[31:0]};
  endfunction

  function automatic logic [63:0] mag64(logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  // Saturate an unsigned quotient with its sign into the Q16.16 range.
  function automatic logic [32:0] tq(logic [31:0] q, logic ov, logic neg);
    if (!neg) begin
      if (ov || q[31]) return {1'b1, QMAX};
      return {1'b0, q};
    end
    if (ov || q > 32'h80000000) return {1'b1, QMIN};
    return {1'b0, 32'(-q)};
  endfunction

  // Input beat.
  logic [1:0]              act_r;
  logic [IDX_W-1:0]        slot_r;
  logic [159:0]            vin_r;
  logic [IDX_W-1:0]        ca, cb, cc;

  // Memories.
  logic [159:0]            vmem [MAX_VERTICES];
  logic [95:0]             smem [MAX_VERTICES];
  logic [159:0]            vq;
  logic [95:0]             sq;
  logic [IDX_W-1:0]        vaddr, s_ra, s_wa, csel;
  logic                    s_we;
  logic [95:0]             s_wd;

  // Working registers.
  logic signed [31:0]      vpx [3], vpy [3], vpz [3], vtu [3], vtv [3];
  logic signed [31:0]      e1 [3], e2 [3];
  logic signed [31:0]      x1, x2, y1, y2;
  logic signed [63:0]      prod, ptmp;
  logic signed [63:0]      res [7];
  logic signed [31:0]      t [3];
  logic                    sat;
  logic [1:0]              st;
  logic [63:0]             mg [3];
  logic                    nneg [3];
  logic [63:0]             m;
  logic signed [15:0]      nsv [3];
  logic signed [49:0]      dot;
  logic [31:0]             nn;
  logic signed [63:0]      pn;
  logic                    neg_r;

  logic signed [31:0]      mul_a, mul_b;
  logic signed [63:0]      mul_p;
  logic signed [63:0]      pn_w;
  logic [3:0]              k;
  logic [1:0]              i2;
  logic [3:0]              km1;
  logic [1:0]              vi;
  logic [2:0]              ni;

  logic                    dv_start, dv_done, dv_ovf;
  logic [79:0]             dv_num;
  logic [63:0]             dv_den;
  logic [31:0]             dv_q;

  logic [32:0]             dl [10];
  logic [63:0]             m01;
  logic [33:0]             pq;
  logic [32:0]             pd_c;
  logic [32:0]             ax, ay, az;
  logic [32:0]             tqv;

  assign k   = cmd.idx[3:0];
  assign i2  = cmd.idx[1:0];
  assign km1 = k - 4'd1;
  assign vi  = i2 - 2'd1;
  assign ni  = 3'(i2) + 3'd1;

  always_comb begin
    unique case (i2)
      2'd0:    csel = ca;
      2'd1:    csel = cb;
      default: csel = cc;
    endcase
  end

  genvar gi;
  generate
    for (gi = 0; gi < 3; gi++) begin : g_n
      assign nsv[gi] = nneg[gi] ? 16'(-$signed(mg[gi][15:0])) : $signed(mg[gi][15:0]);
    end
  endgenerate

  // Shared multiplier operand select.
  always_comb begin
    mul_a = x1;
    mul_b = y2;
    if (cmd.op == OP_PMUL) begin
      unique case (k)
        4'd0:    begin mul_a = t[0]; mul_b = 32'(nsv[0]); end
        4'd1:    begin mul_a = t[1]; mul_b = 32'(nsv[1]); end
        4'd2:    begin mul_a = t[2]; mul_b = 32'(nsv[2]); end
        4'd3:    begin mul_a = 32'(nsv[0]); mul_b = 32'(nsv[0]); end
        4'd4:    begin mul_a = 32'(nsv[1]); mul_b = 32'(nsv[1]); end
        default: begin mul_a = 32'(nsv[2]); mul_b = 32'(nsv[2]); end
      endcase
    end else begin
      unique case (k)
        4'd0:    begin mul_a = x1;    mul_b = y2;    end
        4'd1:    begin mul_a = x2;    mul_b = y1;    end
        4'd2:    begin mul_a = e1[0]; mul_b = y2;    end
        4'd3:    begin mul_a = e2[0]; mul_b = y1;    end
        4'd4:    begin mul_a = e1[1]; mul_b = y2;    end
        4'd5:    begin mul_a = e2[1]; mul_b = y1;    end
        4'd6:    begin mul_a = e1[2]; mul_b = y2;    end
        4'd7:    begin mul_a = e2[2]; mul_b = y1;    end
        4'd8:    begin mul_a = e2[1]; mul_b = e1[2]; end
        4'd9:    begin mul_a = e2[2]; mul_b = e1[1]; end
        4'd10:   begin mul_a = e2[2]; mul_b = e1[0]; end
        4'd11:   begin mul_a = e2[0]; mul_b = e1[2]; end
        4'd12:   begin mul_a = e2[0]; mul_b = e1[1]; end
        default: begin mul_a = e2[1]; mul_b = e1[0]; end
      endcase
    end
  end

  assign mul_p = mul_a * mul_b;
  assign pn_w  = dot * nsv[i2];

  // Edge and UV deltas.
  assign dl[0] = sub_sat(vpx[1], vpx[0]);
  assign dl[1] = sub_sat(vpy[1], vpy[0]);
  assign dl[2] = sub_sat(vpz[1], vpz[0]);
  assign dl[3] = sub_sat(vpx[2], vpx[0]);
  assign dl[4] = sub_sat(vpy[2], vpy[0]);
  assign dl[5] = sub_sat(vpz[2], vpz[0]);
  assign dl[6] = sub_sat(vtu[1], vtu[0]);
  assign dl[7] = sub_sat(vtu[2], vtu[0]);
  assign dl[8] = sub_sat(vtv[1], vtv[0]);
  assign dl[9] = sub_sat(vtv[2], vtv[0]);

  assign m01 = (mag64(res[4]) > mag64(res[5])) ? mag64(res[4]) : mag64(res[5]);

  // Divider operands.
  assign dv_start = (cmd.op == OP_DIVGO) || (cmd.op == OP_PDGO);
  always_comb begin
    if (cmd.op == OP_PDGO) begin
      dv_num = {16'd0, mag64(pn)};
      dv_den = {32'd0, nn};
    end else begin
      dv_num = {mag64(res[ni]), 16'd0};
      dv_den = mag64(res[0]);
    end
  end

  tta_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dv_start),
    .num   (dv_num),
    .den   (dv_den),
    .done  (dv_done),
    .quo   (dv_q),
    .ovf   (dv_ovf)
  );

  assign tqv  = tq(dv_q, dv_ovf, neg_r);
  assign pq   = neg_r ? 34'(-{2'b00, dv_q}) : {2'b00, dv_q};
  assign pd_c = clip34({t[i2][31], t[i2][31], t[i2]} - $signed(pq));
  assign ax   = clip34({{2{sq[31]}}, sq[31:0]}   + {{2{t[0][31]}}, t[0]});
  assign ay   = clip34({{2{sq[63]}}, sq[63:32]}  + {{2{t[1][31]}}, t[1]});
  assign az   = clip34({{2{sq[95]}}, sq[95:64]}  + {{2{t[2][31]}}, t[2]});

  // Memory ports.
  assign vaddr = csel;
  assign s_ra  = (cmd.op == OP_ACR || cmd.op == OP_ACW) ? csel : slot_r;

  always_comb begin
    s_we = 1'b0;
    s_wa = slot_r;
    s_wd = '0;
    unique case (cmd.op)
      OP_CLR:  begin s_we = 1'b1; s_wa = cmd.idx; end
      OP_LOAD: begin s_we = 1'b1; s_wa = slot_r; end
      OP_ACW:  begin s_we = 1'b1; s_wa = csel; s_wd = {az[31:0], ay[31:0], ax[31:0]}; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) vmem[slot_r] <= vin_r;
    vq <= vmem[vaddr];
  end

  always_ff @(posedge clk) begin
    if (s_we) smem[s_wa] <= s_wd;
    sq <= smem[s_ra];
  end

  // Operation sequencing.
  always_ff @(posedge clk) begin
    if (cmd.idle && in_valid) begin
      act_r  <= action;
      slot_r <= vertex_slot;
      vin_r  <= {tex_v, tex_u, pos_z, pos_y, pos_x};
      ca     <= corner_a;
      cb     <= corner_b;
      cc     <= corner_c;
      t[0]   <= '0;
      t[1]   <= '0;
      t[2]   <= '0;
      sat    <= 1'b0;
      st     <= ST_OK;
    end
    prod <= mul_p;
    unique case (cmd.op)
      OP_RDSC: begin
        t[0] <= sq[31:0];
        t[1] <= sq[63:32];
        t[2] <= sq[95:64];
      end
      OP_RDV: begin
        if (i2 != 2'd0) begin
          vpx[vi] <= vq[31:0];
          vpy[vi] <= vq[63:32];
          vpz[vi] <= vq[95:64];
          vtu[vi] <= vq[127:96];
          vtv[vi] <= vq[159:128];
        end
      end
      OP_DELTA: begin
        e1[0] <= dl[0][31:0];
        e1[1] <= dl[1][31:0];
        e1[2] <= dl[2][31:0];
        e2[0] <= dl[3][31:0];
        e2[1] <= dl[4][31:0];
        e2[2] <= dl[5][31:0];
        x1    <= dl[6][31:0];
        x2    <= dl[7][31:0];
        y1    <= dl[8][31:0];
        y2    <= dl[9][31:0];
        sat   <= sat | dl[0][32] | dl[1][32] | dl[2][32] | dl[3][32] | dl[4][32]
               | dl[5][32] | dl[6][32] | dl[7][32] | dl[8][32] | dl[9][32];
      end
      OP_MUL: begin
        if (k != 4'd0) begin
          if (!km1[0]) ptmp <= prod;
          else         res[km1[3:1]] <= ptmp - prod;
        end
      end
      OP_DEGEN: begin
        t[0] <= '0;
        t[1] <= '0;
        t[2] <= '0;
        sat  <= 1'b0;
        st   <= ST_DEGEN;
      end
      OP_DIVGO, OP_PDGO: begin
        neg_r <= (cmd.op == OP_PDGO) ? pn[63] : (res[ni][63] ^ res[0][63]);
      end
      OP_DIVW: begin
        if (dv_done) begin
          t[i2] <= tqv[31:0];
          sat   <= sat | tqv[32];
        end
      end
      OP_NSET: begin
        mg[0]   <= mag64(res[4]);
        mg[1]   <= mag64(res[5]);
        mg[2]   <= mag64(res[6]);
        nneg[0] <= res[4][63];
        nneg[1] <= res[5][63];
        nneg[2] <= res[6][63];
        m       <= (m01 > mag64(res[6])) ? m01 : mag64(res[6]);
      end
      OP_NSHIFT: begin
        if (stat.m_big) begin
          mg[0] <= mg[0] >> 1;
          mg[1] <= mg[1] >> 1;
          mg[2] <= mg[2] >> 1;
          m     <= m >> 1;
        end
      end
      OP_PMUL: begin
        if (k == 4'd0) begin
          dot <= '0;
          nn  <= '0;
        end else if (k <= 4'd3) begin
          dot <= dot + $signed(prod[49:0]);
        end else begin
          nn <= nn + prod[31:0];
        end
      end
      OP_PNUM: pn <= pn_w;
      OP_PDW: begin
        if (dv_done) begin
          t[i2] <= pd_c[31:0];
          sat   <= sat | pd_c[32];
        end
      end
      OP_ACW: sat <= sat | ax[32] | ay[32] | az[32];
      default: ;
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_RESULT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_RESULT) begin
      status    <= st;
      tangent_x <= t[0];
      tangent_y <= t[1];
      tangent_z <= t[2];
      saturated <= sat;
    end
  end

  assign stat.act      = act_r;
  assign stat.d_zero   = res[0] == 64'sd0;
  assign stat.m_zero   = m == 64'd0;
  assign stat.m_big    = m[63:15] != '0;
  assign stat.div_done = dv_done;
  assign stat.out_full = out_valid && !out_ready;

endmodule

// ===== sv/tta_ctrl.sv =====
// Controller state machine that sequences the datapath operations.
module tta_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  tta_pkg::stat_t  stat,
  output tta_pkg::cmd_t   cmd
);
  import tta_pkg::*;

  typedef enum logic [21:0] {
    S_CLR   = 22'h000001,
    S_IDLE  = 22'h000002,
    S_DISP  = 22'h000004,
    S_LOAD  = 22'h000008,
    S_RDS   = 22'h000010,
    S_RDSC  = 22'h000020,
    S_RDV   = 22'h000040,
    S_DELTA = 22'h000080,
    S_MUL   = 22'h000100,
    S_CHKD  = 22'h000200,
    S_DEGEN = 22'h000400,
    S_DIVGO = 22'h000800,
    S_DIVW  = 22'h001000,
    S_NSET  = 22'h002000,
    S_NORM  = 22'h004000,
    S_PMUL  = 22'h008000,
    S_PNUM  = 22'h010000,
    S_PDGO  = 22'h020000,
    S_PDW   = 22'h040000,
    S_ACR   = 22'h080000,
    S_ACW   = 22'h100000,
    S_DONE  = 22'h200000
  } state_t;

  state_t           state, state_next;
  logic [IDX_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd.idle   = 1'b0;
    cmd.op     = OP_NONE;
    cmd.idx    = cnt;
    unique case (state)
      S_CLR: begin
        cmd.op = OP_CLR;
        if (cnt == IDX_W'(MAX_VERTICES - 1)) begin
          state_next = S_IDLE;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_IDLE: begin
        cmd.idle = 1'b1;
        cnt_next = '0;
        if (in_valid) state_next = S_DISP;
      end
      S_DISP: begin
        priority case (stat.act)
          ACT_LOAD: state_next = S_LOAD;
          ACT_TRI:  state_next = S_RDV;
          ACT_READ: state_next = S_RDS;
          default:  state_next = S_DONE;
        endcase
      end
      S_LOAD: begin
        cmd.op     = OP_LOAD;
        state_next = S_DONE;
      end
      S_RDS: begin
        cmd.op     = OP_RDS;
        state_next = S_RDSC;
      end
      S_RDSC: begin
        cmd.op     = OP_RDSC;
        state_next = S_DONE;
      end
      S_RDV: begin
        cmd.op = OP_RDV;
        if (cnt == IDX_W'(3)) begin
          state_next = S_DELTA;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_DELTA: begin
        cmd.op     = OP_DELTA;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.op = OP_MUL;
        if (cnt == IDX_W'(MUL_LAST)) begin
          state_next = S_CHKD;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_CHKD: begin
        state_next = stat.d_zero ? S_DEGEN : S_DIVGO;
      end
      S_DEGEN: begin
        cmd.op     = OP_DEGEN;
        state_next = S_DONE;
      end
      S_DIVGO: begin
        cmd.op     = OP_DIVGO;
        state_next = S_DIVW;
      end
      S_DIVW: begin
        cmd.op = OP_DIVW;
        if (stat.div_done) begin
          if (cnt == IDX_W'(2)) begin
            state_next = S_NSET;
            cnt_next   = '0;
          end else begin
            state_next = S_DIVGO;
            cnt_next   = cnt + 1'b1;
          end
        end
      end
      S_NSET: begin
        cmd.op     = OP_NSET;
        state_next = S_NORM;
      end
      S_NORM: begin
        cmd.op = OP_NSHIFT;
        priority if (stat.m_zero) state_next = S_ACR;
        else if (!stat.m_big)     state_next = S_PMUL;
      end
      S_PMUL: begin
        cmd.op = OP_PMUL;
        if (cnt == IDX_W'(PMUL_LAST)) begin
          state_next = S_PNUM;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_PNUM: begin
        cmd.op     = OP_PNUM;
        state_next = S_PDGO;
      end
      S_PDGO: begin
        cmd.op     = OP_PDGO;
        state_next = S_PDW;
      end
      S_PDW: begin
        cmd.op = OP_PDW;
        if (stat.div_done) begin
          if (cnt == IDX_W'(2)) begin
            state_next = S_ACR;
            cnt_next   = '0;
          end else begin
            state_next = S_PNUM;
            cnt_next   = cnt + 1'b1;
          end
        end
      end
      S_ACR: begin
        cmd.op     = OP_ACR;
        state_next = S_ACW;
      end
      S_ACW: begin
        cmd.op = OP_ACW;
        if (cnt == IDX_W'(2)) begin
          state_next = S_DONE;
          cnt_next   = '0;
        end else begin
          state_next = S_ACR;
          cnt_next   = cnt + 1'b1;
        end
      end
      S_DONE: begin
        if (!stat.out_full) begin
          cmd.op     = OP_RESULT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLR;
        cnt_next   = '0;
      end
    endcase
  end

endmodule

// ===== sv/triangle_tangent_accumulator_top.sv =====
// Top level of the per-vertex tangent accumulator: controller plus datapath.
// Time from accepted beat to result depends on the action and the triangle: a degenerate
// triangle skips the divisions, a zero-normal one skips the projection, and others run three divisions,
// a normal-shift loop and three projection divisions; output stalls add to it.
// One item at a time: the next beat is taken the cycle after the result is registered.
// After reset, clear the 4096 tangent sums, one entry a cycle, with in_ready low.
module triangle_tangent_accumulator_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        action,
  input  logic [tta_pkg::IDX_W-1:0]         vertex_slot,
  input  logic signed [tta_pkg::Q_W-1:0]    pos_x,
  input  logic signed [tta_pkg::Q_W-1:0]    pos_y,
  input  logic signed [tta_pkg::Q_W-1:0]    pos_z,
  input  logic signed [tta_pkg::Q_W-1:0]    tex_u,
  input  logic signed [tta_pkg::Q_W-1:0]    tex_v,
  input  logic [tta_pkg::IDX_W-1:0]         corner_a,
  input  logic [tta_pkg::IDX_W-1:0]         corner_b,
  input  logic [tta_pkg::IDX_W-1:0]         corner_c,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        status,
  output logic signed [tta_pkg::Q_W-1:0]    tangent_x,
  output logic signed [tta_pkg::Q_W-1:0]    tangent_y,
  output logic signed [tta_pkg::Q_W-1:0]    tangent_z,
  output logic                              saturated
);
  import tta_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Take an input beat only while the controller sits idle.
  assign in_ready = cmd.idle;

  // Sequence: dispatch on action, then load a vertex, read its sums, or step the datapath through reads,
  // products, divisions, normal scaling, projection and the three read-modify-writes for a triangle.
  tta_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Hold the memories, the arithmetic and the result register; the result beat
  // waits there while the controller goes back to idle.
  tta_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_valid    (in_valid),
    .action      (action),
    .vertex_slot (vertex_slot),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .tex_u       (tex_u),
    .tex_v       (tex_v),
    .corner_a    (corner_a),
    .corner_b    (corner_b),
    .corner_c    (corner_c),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .status      (status),
    .tangent_x   (tangent_x),
    .tangent_y   (tangent_y),
    .tangent_z   (tangent_z),
    .saturated   (saturated)
  );

endmodule
